>>> rtl/lir_pkg.sv
// Package for the lookup-table image remapper.
// Holds sizes, the command record passed from the front end to the back end,
// the configuration record and the state codes. Depends on nothing.
package lir_pkg;

   // Frame store geometry and fixed-point position format.
   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int FRACTION_BITS  = 8;
   localparam int X_BITS         = $clog2(MAX_WIDTH);
   localparam int Y_BITS         = $clog2(MAX_HEIGHT);
   localparam int ADDR_BITS      = $clog2(MAX_WIDTH * MAX_HEIGHT);

   // Register, channel and coordinate widths.
   localparam int DIM_BITS       = 11;
   localparam int COORD_BITS     = 16;
   localparam int CHAN_BITS      = 8;
   localparam int PIX_BITS       = 3 * CHAN_BITS;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int REQ_DATA_BITS  = 80;
   localparam int RSP_DATA_BITS  = 32;
   localparam int RSP_USER_BITS  = 2;
   localparam logic [COORD_BITS-1:0] UNMAPPED_MARK = '1;
   localparam logic [CHAN_BITS-1:0]  ALPHA_OPAQUE  = '1;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SRC_W    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SRC_H    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_OUT_W    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_OUT_H    = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BILINEAR = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ALPHA    = 3'd5;

   // Divider and position widths. A bilinear coordinate that reaches the
   // divider never exceeds the working dimension.
   localparam int CRD_BITS       = ((X_BITS > Y_BITS) ? X_BITS : Y_BITS) + 1;
   localparam int DIV_N_BITS     = CRD_BITS + FRACTION_BITS;
   localparam int DIV_D_BITS     = CRD_BITS - 1;
   localparam int DIV_CNT_BITS   = $clog2(DIV_N_BITS + 1);
   localparam int POS_BITS       = DIV_N_BITS + 1;
   localparam int IDX_BITS       = POS_BITS - FRACTION_BITS;
   localparam int WGT_BITS       = 2 * FRACTION_BITS + 1;
   localparam int ACC_BITS       = CHAN_BITS + 2 * FRACTION_BITS;
   localparam logic [FRACTION_BITS:0] WEIGHT_ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
   localparam logic [POS_BITS-1:0]    HALF_PIXEL = POS_BITS'(1) << (FRACTION_BITS - 1);

   // Command queue depth.
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_CONST,
      CMD_NEAREST,
      CMD_BILINEAR
   } cmd_kind_type;

   // One classified transaction. For bilinear commands x and y hold the
   // floor of the position plus one, and vx/vy mark which corners lie inside
   // the source image (bit 0 for the left or upper corner).
   typedef struct packed {
      cmd_kind_type               kind;
      logic [IDX_BITS-1:0]        x;
      logic [IDX_BITS-1:0]        y;
      logic [FRACTION_BITS-1:0]   fx;
      logic [FRACTION_BITS-1:0]   fy;
      logic [1:0]                 vx;
      logic [1:0]                 vy;
      logic [PIX_BITS-1:0]        pix;
      logic                       unmapped;
      logic                       range_err;
   } cmd_type;

   // Configuration as seen by the datapath, dimensions already saturated.
   typedef struct packed {
      logic [DIM_BITS-1:0] src_w;
      logic [DIM_BITS-1:0] src_h;
      logic [DIM_BITS-1:0] work_w;
      logic [DIM_BITS-1:0] work_h;
      logic                bilinear;
      logic                alpha;
   } cfg_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_BIL,
      B_OUT
   } back_state_type;

endpackage

>>> rtl/lir_div.sv
// Restoring divider of the remapper, one quotient bit per cycle.
// Used by the front end to scale map coordinates. Depends on lir_pkg.
module lir_div import lir_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_N_BITS-1:0] numer,
   input  logic [DIV_D_BITS-1:0] denom,
   output logic                  done,
   output logic [DIV_N_BITS-1:0] quot
);

   logic [DIV_D_BITS-1:0]   rem_ff;
   logic [DIV_N_BITS-1:0]   quo_ff;
   logic [DIV_D_BITS-1:0]   den_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    done_ff;
   logic [DIV_D_BITS:0]     trial;
   logic [DIV_D_BITS:0]     diff;
   logic                    fits;

   // Shift in the next dividend bit and try to subtract the divisor.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_N_BITS-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == DIV_CNT_BITS'(1));
         if (start) begin
            cnt_ff <= DIV_CNT_BITS'(DIV_N_BITS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - DIV_CNT_BITS'(1);
         end
      end
   end

   // Partial remainder and quotient share one shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= numer;
         den_ff <= denom;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[DIV_D_BITS-1:0] : trial[DIV_D_BITS-1:0];
         quo_ff <= {quo_ff[DIV_N_BITS-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

>>> rtl/lir_front.sv
// Front end of the remapper: accepts request transactions, classifies them
// and scales bilinear positions before queuing a command.
// Depends on lir_pkg and lir_div.
module lir_front import lir_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tuser,
   input  logic                     q_full,
   output logic                     q_push,
   output cmd_type                  q_cmd
);

   front_state_type          state_ff, state_in;
   logic [CRD_BITS-1:0]      col_ff, line_ff;
   logic                     div_start;
   logic                     x_done, y_done;
   logic [DIV_N_BITS-1:0]    x_quot, y_quot;
   logic [DIV_N_BITS-1:0]    x_num, y_num;
   logic [DIV_D_BITS-1:0]    x_den, y_den;
   logic [X_BITS-1:0]        load_x;
   logic [Y_BITS-1:0]        load_y;
   logic [PIX_BITS-1:0]      load_pix;
   logic [COORD_BITS-1:0]    col, line;
   logic                     accept, unm;
   logic                     col_in_work, line_in_work, col_in_src, line_in_src;
   logic                     bil_far;
   logic [POS_BITS-1:0]      px, py;
   logic [IDX_BITS-1:0]      xi, yi;

   // Request fields.
   always_comb begin
      load_x   = req_tdata[9:0];
      load_y   = req_tdata[19:10];
      load_pix = req_tdata[43:20];
      col      = req_tdata[59:44];
      line     = req_tdata[75:60];
   end

   always_comb begin
      unm          = (col == UNMAPPED_MARK) || (line == UNMAPPED_MARK);
      col_in_work  = col < COORD_BITS'(cfg.work_w);
      line_in_work = line < COORD_BITS'(cfg.work_h);
      col_in_src   = col < COORD_BITS'(cfg.src_w);
      line_in_src  = line < COORD_BITS'(cfg.src_h);
      // Beyond one past the working edge every corner lies outside the image.
      bil_far      = (col > COORD_BITS'(cfg.work_w)) || (line > COORD_BITS'(cfg.work_h));
   end

   // Divider operands: coordinate scaled by the fraction, over dimension minus one.
   always_comb begin
      x_num = {col[CRD_BITS-1:0], FRACTION_BITS'(0)};
      y_num = {line[CRD_BITS-1:0], FRACTION_BITS'(0)};
      x_den = DIV_D_BITS'(cfg.work_w - DIM_BITS'(1));
      y_den = DIV_D_BITS'(cfg.work_h - DIM_BITS'(1));
   end

   lir_div u_div_x (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (x_num), .denom (x_den), .done (x_done), .quot (x_quot)
   );

   lir_div u_div_y (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (y_num), .denom (y_den), .done (y_done), .quot (y_quot)
   );

   // Position plus half a pixel: col*W/(W-1) = col + col/(W-1).
   always_comb begin
      px = POS_BITS'({col_ff, FRACTION_BITS'(0)}) + HALF_PIXEL;
      py = POS_BITS'({line_ff, FRACTION_BITS'(0)}) + HALF_PIXEL;
      if (cfg.work_w != DIM_BITS'(1)) begin
         px = px + POS_BITS'(x_quot);
      end
      if (cfg.work_h != DIM_BITS'(1)) begin
         py = py + POS_BITS'(y_quot);
      end
      xi = px[POS_BITS-1:FRACTION_BITS];
      yi = py[POS_BITS-1:FRACTION_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         col_ff  <= col[CRD_BITS-1:0];
         line_ff <= line[CRD_BITS-1:0];
      end
   end

   // Classification and sequencing.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      accept     = 1'b0;
      div_start  = 1'b0;
      q_push     = 1'b0;
      q_cmd      = '0;
      q_cmd.kind = CMD_CONST;
      unique case (state_ff)
         F_IDLE: begin
            req_tready = !q_full;
            accept     = req_tvalid && !q_full;
            if (accept) begin
               if (!req_tuser) begin
                  q_push     = 1'b1;
                  q_cmd.kind = CMD_LOAD;
                  q_cmd.x    = IDX_BITS'(load_x);
                  q_cmd.y    = IDX_BITS'(load_y);
                  q_cmd.pix  = load_pix;
               end else if (unm) begin
                  q_push         = 1'b1;
                  q_cmd.unmapped = 1'b1;
               end else if (!cfg.bilinear) begin
                  q_push = 1'b1;
                  if (!col_in_work || !line_in_work) begin
                     q_cmd.range_err = 1'b1;
                  end else if (col_in_src && line_in_src) begin
                     q_cmd.kind = CMD_NEAREST;
                     q_cmd.x    = IDX_BITS'(col);
                     q_cmd.y    = IDX_BITS'(line);
                  end
               end else if (bil_far) begin
                  q_push = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = F_DIV;
               end
            end
         end
         F_DIV: begin
            if (x_done && y_done) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            q_cmd.kind  = CMD_BILINEAR;
            q_cmd.x     = xi;
            q_cmd.y     = yi;
            q_cmd.fx    = px[FRACTION_BITS-1:0];
            q_cmd.fy    = py[FRACTION_BITS-1:0];
            q_cmd.vx[0] = (xi != '0) && ((xi - IDX_BITS'(1)) < IDX_BITS'(cfg.src_w));
            q_cmd.vx[1] = xi < IDX_BITS'(cfg.src_w);
            q_cmd.vy[0] = (yi != '0) && ((yi - IDX_BITS'(1)) < IDX_BITS'(cfg.src_h));
            q_cmd.vy[1] = yi < IDX_BITS'(cfg.src_h);
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/lir_fifo.sv
// Short command queue between the front end and the back end.
// Register based, one push and one pop per cycle. Depends on lir_pkg.
module lir_fifo import lir_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type                  slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ff, rd_ff;
   logic [FIFO_PTR_BITS:0]   cnt_ff;

   assign full  = (cnt_ff == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + FIFO_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + FIFO_PTR_BITS'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + (FIFO_PTR_BITS+1)'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - (FIFO_PTR_BITS+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   // Queue discipline.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("command queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("command queue read while empty");

endmodule

>>> rtl/lir_back.sv
// Back end of the remapper: owns the frame store, executes queued commands
// and holds the response register. Depends on lir_pkg.
module lir_back import lir_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     q_empty,
   input  cmd_type                  q_head,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [RSP_USER_BITS-1:0] rsp_tuser
);

   logic [PIX_BITS-1:0]      store [MAX_WIDTH * MAX_HEIGHT];
   back_state_type           state_ff, state_in;
   cmd_type                  cmd_ff;
   logic [2:0]               step_ff, step_in;
   logic [PIX_BITS-1:0]      rd_ff;
   logic                     cval_ff, cval_in;
   logic [WGT_BITS-1:0]      wgt_ff, wgt_in;
   logic [ACC_BITS-1:0]      acc_ff [3];
   logic                     acc_clear;
   logic                     mem_we, mem_re;
   logic [ADDR_BITS-1:0]     mem_addr;
   logic                     out_free, out_load;
   logic                     dx, dy;
   logic [IDX_BITS-1:0]      cx, cy;
   logic [FRACTION_BITS:0]   wx, wy;
   logic [ADDR_BITS-1:0]     corner_addr, head_addr;
   logic [CHAN_BITS-1:0]     res_chan [3];
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [RSP_USER_BITS-1:0] rsp_user_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Corner of the current bilinear step and its weight.
   always_comb begin
      dx          = step_ff[0];
      dy          = step_ff[1];
      cx          = cmd_ff.x - IDX_BITS'(1) + IDX_BITS'(dx);
      cy          = cmd_ff.y - IDX_BITS'(1) + IDX_BITS'(dy);
      wx          = dx ? (FRACTION_BITS+1)'(cmd_ff.fx) : WEIGHT_ONE - (FRACTION_BITS+1)'(cmd_ff.fx);
      wy          = dy ? (FRACTION_BITS+1)'(cmd_ff.fy) : WEIGHT_ONE - (FRACTION_BITS+1)'(cmd_ff.fy);
      wgt_in      = WGT_BITS'(wx) * WGT_BITS'(wy);
      corner_addr = ADDR_BITS'(cy[Y_BITS-1:0]) * ADDR_BITS'(MAX_WIDTH)
                    + ADDR_BITS'(cx[X_BITS-1:0]);
      head_addr   = ADDR_BITS'(q_head.y[Y_BITS-1:0]) * ADDR_BITS'(MAX_WIDTH)
                    + ADDR_BITS'(q_head.x[X_BITS-1:0]);
   end

   // Result channels by command kind.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         unique case (cmd_ff.kind)
            CMD_NEAREST:  res_chan[k] = rd_ff[k*CHAN_BITS +: CHAN_BITS];
            CMD_BILINEAR: res_chan[k] = acc_ff[k][ACC_BITS-1 -: CHAN_BITS];
            default:      res_chan[k] = '0;
         endcase
      end
   end

   // Command sequencing.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = head_addr;
      cval_in   = 1'b0;
      acc_clear = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_head.kind)
                  CMD_LOAD: begin
                     mem_we = 1'b1;
                  end
                  CMD_NEAREST: begin
                     mem_re   = 1'b1;
                     state_in = B_OUT;
                  end
                  CMD_BILINEAR: begin
                     acc_clear = 1'b1;
                     step_in   = '0;
                     state_in  = B_BIL;
                  end
                  default: begin
                     state_in = B_OUT;
                  end
               endcase
            end
         end
         B_BIL: begin
            // Steps 0..3 read one corner each; each corner is accumulated in the step after its read.
            if (step_ff[2]) begin
               state_in = B_OUT;
            end else begin
               mem_addr = corner_addr;
               cval_in  = cmd_ff.vx[dx] && cmd_ff.vy[dy];
               mem_re   = cval_in;
               step_in  = step_ff + 3'd1;
            end
         end
         B_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= '0;
         cval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cval_ff  <= cval_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Frame store: one access per cycle, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= q_head.pix;
      end
      if (mem_re) begin
         rd_ff <= store[mem_addr];
      end
   end

   // Command latch, corner weight and accumulators.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_head;
      end
      wgt_ff <= wgt_in;
      for (int k = 0; k < 3; k++) begin
         if (acc_clear) begin
            acc_ff[k] <= '0;
         end else if (cval_ff) begin
            acc_ff[k] <= acc_ff[k] + ACC_BITS'(rd_ff[k*CHAN_BITS +: CHAN_BITS]) * ACC_BITS'(wgt_ff);
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {(cfg.alpha && !cmd_ff.unmapped) ? ALPHA_OPAQUE : CHAN_BITS'(0),
                         res_chan[2], res_chan[1], res_chan[0]};
         rsp_user_ff <= {cmd_ff.range_err, cmd_ff.unmapped};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // An unmapped pixel is fully transparent black and never a range error.
   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[0]) |-> (rsp_data_ff == '0 && !rsp_user_ff[1]))
      else $error("unmapped response carries data or a range error");
   // The bilinear step counter stops after the last corner.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_BIL) |-> (step_ff <= 3'd4))
      else $error("bilinear step counter overran");

endmodule

>>> rtl/lut_image_remap.sv
// Lookup-table image remapper. Load transactions (tuser 0) write one pixel
// into a 1024 x 1024 frame store at one per cycle while the command queue
// drains; remap transactions (tuser 1) return one pixel each. An unmapped or
// nearest-mode remap passes through the back end's idle and output states,
// and the front end can accept further requests meanwhile while the queue has
// room. A bilinear remap holds the front end while the 19-step position
// divider runs and while the command is handed to the queue. Its response
// becomes valid once the back end has made up to four single-port frame store
// reads and finished the accumulate. The store holds no reset contents and
// needs no clearing pass.
// Depends on lir_pkg, lir_front, lir_fifo and lir_back.
module lut_image_remap import lir_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Requests.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // load_x[9:0], load_y[19:10], chan0_in, chan1_in, chan2_in[43:20],
   // map_column[59:44], map_line[75:60], zero fill
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // action
   input  logic                     req_tuser,
   // Responses.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // chan0_out, chan1_out, chan2_out, alpha_out from the lowest byte up
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // unmapped_flag, range_error
   output logic [RSP_USER_BITS-1:0] rsp_tuser,
   // Configuration.
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [DIM_BITS-1:0]      csr_wdata
);

   logic [DIM_BITS-1:0] src_w_ff, src_h_ff, out_w_ff, out_h_ff;
   logic                bil_ff, alpha_ff;
   logic [DIM_BITS-1:0] sw, sh, ow, oh;
   cfg_type             cfg;
   logic                q_push, q_full, q_pop, q_empty;
   cmd_type             q_cmd, q_head;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= DIM_BITS'(1024);
         src_h_ff <= DIM_BITS'(1024);
         out_w_ff <= DIM_BITS'(1024);
         out_h_ff <= DIM_BITS'(1024);
         bil_ff   <= 1'b0;
         alpha_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SRC_W:    src_w_ff <= csr_wdata;
            CSR_SRC_H:    src_h_ff <= csr_wdata;
            CSR_OUT_W:    out_w_ff <= csr_wdata;
            CSR_OUT_H:    out_h_ff <= csr_wdata;
            CSR_BILINEAR: bil_ff   <= csr_wdata[0];
            CSR_ALPHA:    alpha_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Saturate dimensions and form the working area.
   always_comb begin
      sw = (src_w_ff == '0) ? DIM_BITS'(1) :
           (src_w_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : src_w_ff;
      sh = (src_h_ff == '0) ? DIM_BITS'(1) :
           (src_h_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : src_h_ff;
      ow = (out_w_ff == '0) ? DIM_BITS'(1) :
           (out_w_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : out_w_ff;
      oh = (out_h_ff == '0) ? DIM_BITS'(1) :
           (out_h_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : out_h_ff;
      cfg.src_w    = sw;
      cfg.src_h    = sh;
      cfg.work_w   = (ow > sw) ? ow : sw;
      cfg.work_h   = (oh > sh) ? oh : sh;
      cfg.bilinear = bil_ff;
      cfg.alpha    = alpha_ff;
   end

   lir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   lir_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   lir_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lut_image_remap: stream driver, response monitor
// and a fixed-point remap predictor. Depends on lir_pkg and the RTL top level.
module tb;
   import lir_pkg::*;

   typedef struct packed {
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [7:0] alpha;
      logic       unmapped;
      logic       rerr;
   } pixel_result_type;

   typedef struct {
      bit               action;
      bit [9:0]         lx;
      bit [9:0]         ly;
      bit [7:0]         c0;
      bit [7:0]         c1;
      bit [7:0]         c2;
      bit [15:0]        mcol;
      bit [15:0]        mline;
      pixel_result_type want;
   } remap_txn_type;

   localparam int ACT_LOAD  = 0;
   localparam int ACT_REMAP = 1;
   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [DIM_BITS-1:0] csr_wdata = '0;

   // Predictor state: shadow registers and the pixels written so far.
   bit [10:0]  reg_src_w, reg_src_h, reg_out_w, reg_out_h;
   bit         reg_bilinear, reg_alpha;
   bit [23:0]  frame_pixels [int];
   bit         unwritten_read;
   int         loaded_x[$], loaded_y[$];

   remap_txn_type     pending_txns[$];
   pixel_result_type  expected_pixels[$];
   remap_txn_type     cur_txn;
   bit                req_took = 1'b0;
   int                send_idle_pct = 0, stall_pct = 0;
   int                mismatches = 0, results_seen = 0, loads_sent = 0, remaps_sent = 0;
   int                phases = 0;
   int                cycles = 0;

   always #10 clock = ~clock;

   lut_image_remap i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   function automatic int sat_dim(bit [10:0] v, int max_v);
      if (v < 1) return 1;
      if (v > max_v) return max_v;
      return v;
   endfunction

   // Source read; positions outside the source image read as zero.
   function automatic bit [23:0] source_pixel(longint x, longint y);
      int idx;
      if (x < 0 || y < 0 || x >= sat_dim(reg_src_w, MAX_WIDTH) ||
          y >= sat_dim(reg_src_h, MAX_HEIGHT)) return '0;
      idx = int'(y) * MAX_WIDTH + int'(x);
      if (!frame_pixels.exists(idx)) begin
         unwritten_read = 1'b1;
         return '0;
      end
      return frame_pixels[idx];
   endfunction

   // Fixed-point sample position with pixel centers at half steps.
   function automatic longint sample_position(bit [15:0] c, int w);
      longint den;
      den = (w > 1) ? w - 1 : 1;
      return ((longint'(c) * w) <<< FRACTION_BITS) / den - (1 <<< (FRACTION_BITS - 1));
   endfunction

   function automatic pixel_result_type remap_pixel(bit [15:0] col, bit [15:0] line);
      pixel_result_type r;
      int ww, wh;
      longint px, py, x0, y0, fx, fy, wgt;
      longint wx[2], wy[2], acc[3];
      bit [23:0] p;
      r = '0;
      if (col == UNMAPPED_MARK || line == UNMAPPED_MARK) begin
         r.unmapped = 1'b1;
         return r;
      end
      ww = sat_dim(reg_src_w, MAX_WIDTH);
      if (sat_dim(reg_out_w, MAX_WIDTH) > ww) ww = sat_dim(reg_out_w, MAX_WIDTH);
      wh = sat_dim(reg_src_h, MAX_HEIGHT);
      if (sat_dim(reg_out_h, MAX_HEIGHT) > wh) wh = sat_dim(reg_out_h, MAX_HEIGHT);
      r.alpha = reg_alpha ? ALPHA_OPAQUE : 8'd0;
      if (!reg_bilinear) begin
         if (col >= ww || line >= wh) begin
            r.rerr = 1'b1;
         end else begin
            p = source_pixel(col, line);
            {r.c2, r.c1, r.c0} = p;
         end
         return r;
      end
      // Bilinear: split positions into whole and fraction, weight four corners.
      px = sample_position(col, ww);
      py = sample_position(line, wh);
      x0 = ((px + (1 <<< FRACTION_BITS)) >>> FRACTION_BITS) - 1;
      y0 = ((py + (1 <<< FRACTION_BITS)) >>> FRACTION_BITS) - 1;
      fx = px - (x0 <<< FRACTION_BITS);
      fy = py - (y0 <<< FRACTION_BITS);
      wx[0] = (1 <<< FRACTION_BITS) - fx; wx[1] = fx;
      wy[0] = (1 <<< FRACTION_BITS) - fy; wy[1] = fy;
      acc = '{0, 0, 0};
      for (int dy = 0; dy < 2; dy++)
         for (int dx = 0; dx < 2; dx++) begin
            wgt = wx[dx] * wy[dy];
            p = source_pixel(x0 + dx, y0 + dy);
            for (int k = 0; k < 3; k++) acc[k] += longint'(p[8*k +: 8]) * wgt;
         end
      for (int k = 0; k < 3; k++) acc[k] = acc[k] >>> (2 * FRACTION_BITS);
      r.c0 = (acc[0] > 255) ? 8'd255 : acc[0][7:0];
      r.c1 = (acc[1] > 255) ? 8'd255 : acc[1][7:0];
      r.c2 = (acc[2] > 255) ? 8'd255 : acc[2][7:0];
      return r;
   endfunction

   task automatic queue_load(int x, int y, bit [7:0] c0, bit [7:0] c1, bit [7:0] c2);
      remap_txn_type t;
      t = '{default: '0};
      t.action = ACT_LOAD;
      t.lx = x; t.ly = y; t.c0 = c0; t.c1 = c1; t.c2 = c2;
      t.mcol = $urandom; t.mline = $urandom;
      frame_pixels[y * MAX_WIDTH + x] = {c2, c1, c0};
      loaded_x.push_back(x);
      loaded_y.push_back(y);
      pending_txns.push_back(t);
      loads_sent++;
   endtask

   // Queues a remap unless it would read a pixel that was never loaded.
   function automatic bit queue_remap(bit [15:0] col, bit [15:0] line);
      remap_txn_type t;
      t = '{default: '0};
      unwritten_read = 1'b0;
      t.want = remap_pixel(col, line);
      if (unwritten_read) return 1'b0;
      t.action = ACT_REMAP;
      t.mcol = col; t.mline = line;
      t.lx = $urandom; t.ly = $urandom;
      t.c0 = $urandom; t.c1 = $urandom; t.c2 = $urandom;
      pending_txns.push_back(t);
      remaps_sent++;
      return 1'b1;
   endfunction

   task automatic queue_random_remap();
      int r, ww, wh, k;
      bit [15:0] col, line;
      ww = sat_dim(reg_src_w, MAX_WIDTH);
      if (sat_dim(reg_out_w, MAX_WIDTH) > ww) ww = sat_dim(reg_out_w, MAX_WIDTH);
      wh = sat_dim(reg_src_h, MAX_HEIGHT);
      if (sat_dim(reg_out_h, MAX_HEIGHT) > wh) wh = sat_dim(reg_out_h, MAX_HEIGHT);
      for (int tries = 0; tries < 20; tries++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            col = $urandom; line = $urandom;
            if (r < 4) col = UNMAPPED_MARK; else line = UNMAPPED_MARK;
         end else if (r < 18) begin
            col = $urandom; line = $urandom;
         end else if (r < 32 || loaded_x.size() == 0) begin
            col = $urandom_range(ww - 1); line = $urandom_range(wh - 1);
         end else begin
            k = $urandom_range(loaded_x.size() - 1);
            col = loaded_x[k] + (reg_bilinear ? $urandom_range(1) : 0);
            line = loaded_y[k] + (reg_bilinear ? $urandom_range(1) : 0);
         end
         if (queue_remap(col, line)) return;
      end
      void'(queue_remap(UNMAPPED_MARK, UNMAPPED_MARK));
   endtask

   // Waits until the block is idle, then writes all six registers.
   task automatic write_registers(int sw, int sh, int ow, int oh, int bil, int alp);
      bit [10:0] vals[6];
      vals = '{sw, sh, ow, oh, bil, alp};
      do @(posedge clock);
      while (pending_txns.size() != 0 || req_tvalid || expected_pixels.size() != 0);
      repeat (40) @(posedge clock);
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= i;
         csr_wdata <= vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      reg_src_w = vals[CSR_SRC_W]; reg_src_h = vals[CSR_SRC_H];
      reg_out_w = vals[CSR_OUT_W]; reg_out_h = vals[CSR_OUT_H];
      reg_bilinear = vals[CSR_BILINEAR][0]; reg_alpha = vals[CSR_ALPHA][0];
      loaded_x.delete(); loaded_y.delete();
      phases++;
   endtask

   // One phase: set registers, load source pixels, then random loads and remaps.
   task automatic run_phase(int sw, int sh, int ow, int oh, int bil, int alp,
                            int n_random, int sidle, int stall);
      int w, h;
      write_registers(sw, sh, ow, oh, bil, alp);
      send_idle_pct = sidle;
      stall_pct = stall;
      w = sat_dim(sw, MAX_WIDTH);
      h = sat_dim(sh, MAX_HEIGHT);
      if (w * h <= 256) begin
         for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) queue_load(x, y, $urandom, $urandom, $urandom);
      end else begin
         for (int i = 0; i < 64; i++)
            queue_load($urandom_range(w - 1), $urandom_range(h - 1),
                       $urandom, $urandom, $urandom);
      end
      for (int i = 0; i < n_random; i++) begin
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(3) == 0)
               queue_load($urandom_range(1023), $urandom_range(1023),
                          $urandom, $urandom, $urandom);
            else
               queue_load($urandom_range(w - 1), $urandom_range(h - 1),
                          $urandom, $urandom, $urandom);
         end else begin
            queue_random_remap();
         end
      end
   endtask

   // Request driver: presents the next transaction at the falling edge.
   always @(negedge clock) begin
      remap_txn_type nxt;
      bit drive;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         drive = pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct;
         if (drive) begin
            nxt = pending_txns.pop_front();
            cur_txn <= nxt;
            req_tdata <= {4'b0, nxt.mline, nxt.mcol, nxt.c2, nxt.c1, nxt.c0, nxt.ly, nxt.lx};
            req_tuser <= nxt.action;
         end
         req_tvalid <= drive;
      end
      rsp_tready <= $urandom_range(99) >= stall_pct;
   end

   // Accepted remap transactions queue their expected pixel.
   always @(posedge clock) begin
      req_took <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready && cur_txn.action == ACT_REMAP)
         expected_pixels.push_back(cur_txn.want);
   end

   // Response monitor: compares each result with the oldest expectation.
   always @(posedge clock) begin
      pixel_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[31:24],
                rsp_tuser[0], rsp_tuser[1]};
         results_seen++;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
         end else begin
            want = expected_pixels.pop_front();
            if (got.c0 !== want.c0 || got.c1 !== want.c1 || got.c2 !== want.c2 ||
                got.alpha !== want.alpha || got.unmapped !== want.unmapped ||
                got.rerr !== want.rerr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result %0d: expected c %h %h %h a %h u %b e %b, ",
                           results_seen, want.c0, want.c1, want.c2, want.alpha,
                           want.unmapped, want.rerr,
                           "got c %h %h %h a %h u %b e %b",
                           got.c0, got.c1, got.c2, got.alpha, got.unmapped, got.rerr);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("lut_image_remap regression: fail");
         $finish;
      end
   end

   initial begin
      reg_src_w = 1024; reg_src_h = 1024; reg_out_w = 1024; reg_out_h = 1024;
      reg_bilinear = 1'b0; reg_alpha = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: corner pixels, extreme channels, unmapped markers, range errors.
      write_registers(1024, 1024, 1024, 1024, 0, 0);
      queue_load(0, 0, 8'h00, 8'hFF, 8'h5A);
      queue_load(1023, 1023, 8'hFF, 8'hFF, 8'hFF);
      queue_load(1023, 0, 8'hFF, 8'h00, 8'hA5);
      queue_load(0, 1023, 8'h01, 8'h80, 8'h7F);
      void'(queue_remap(0, 0));
      void'(queue_remap(1023, 1023));
      void'(queue_remap(1023, 0));
      void'(queue_remap(0, 1023));
      void'(queue_remap(UNMAPPED_MARK, 3));
      void'(queue_remap(2, UNMAPPED_MARK));
      void'(queue_remap(UNMAPPED_MARK, UNMAPPED_MARK));
      void'(queue_remap(1024, 0));
      void'(queue_remap(0, 1024));
      void'(queue_remap(16'hFFFE, 16'hFFFE));
      // Bilinear at the full size: at most one corner is read per remap.
      write_registers(1024, 1024, 1024, 1024, 1, 1);
      void'(queue_remap(0, 0));
      void'(queue_remap(1023, 1023));
      void'(queue_remap(16'hFFFE, 0));
      void'(queue_remap(UNMAPPED_MARK, 0));

      // Random phases over sizes, modes and flow control.
      run_phase(8, 6, 8, 6, 0, 1, 200, 0, 0);
      run_phase(8, 6, 16, 12, 1, 1, 200, 76, 0);
      run_phase(0, 0, 0, 0, 1, 1, 100, 0, 76);
      run_phase(2047, 2, 5, 2047, 0, 1, 170, 33, 33);
      run_phase(12, 10, 1024, 3, 1, 0, 170, 0, 76);
      run_phase(1, 16, 4, 1, 0, 0, 130, 76, 0);
      run_phase(1024, 1, 1024, 1, 1, 1, 130, 33, 33);
      run_phase(5, 7, 5, 7, 1, 0, 130, 0, 0);

      do @(posedge clock);
      while (pending_txns.size() != 0 || req_tvalid || expected_pixels.size() != 0);
      repeat (60) @(posedge clock);
      $display("Covered %0d phases: %0d pixel loads and %0d remaps, %0d results checked.",
               phases, loads_sent, remaps_sent, results_seen);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("lut_image_remap regression: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_pixels.size());
         $display("lut_image_remap regression: fail");
      end
      $finish;
   end
endmodule
